// ===== rtl/core/qdra_pkg.sv =====
package qdra_pkg;

    // input item kinds, carried in s_tuser
    typedef enum logic [1:0] {
        CMD_A_EDGE    = 2'd0,
        CMD_B_EDGE    = 2'd1,
        CMD_POS_WRITE = 2'd2,
        CMD_QUERY     = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FAST_LIMIT    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOW_LIMIT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOCKS_PER_US = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_SAMPLES = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_SAMPLES  = 3'd4;

    // field widths
    localparam int FIELD_BITS   = 32;
    localparam int CPU_BITS     = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int PRODUCT_BITS = FIELD_BITS + SAMPLE_BITS;

    // serial divider: dividend wide enough for avg*(n-1)+te, quotient bits per cycle
    localparam int DIV_BITS   = 52;
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = DIV_BITS / DIV_STEP;
    localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TE_DIV,
        ST_SHORT_MUL,
        ST_SHORT_DIV,
        ST_LONG_MUL,
        ST_LONG_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   start;
        logic [DIV_BITS-1:0]    dividend;
        logic [SAMPLE_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [FIELD_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/qdra_div.sv =====
// restoring divider, several quotient bits per cycle
module qdra_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  qdra_pkg::div_req_t req,
    output qdra_pkg::div_rsp_t rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [qdra_pkg::DIV_CNT_BITS-1:0]   cnt_reg;
    logic [qdra_pkg::DIV_BITS-1:0]       quo_reg;
    logic [qdra_pkg::DIV_BITS-1:0]       quo_next;
    logic [qdra_pkg::SAMPLE_BITS-1:0]    rem_reg;
    logic [qdra_pkg::SAMPLE_BITS-1:0]    rem_next;
    logic [qdra_pkg::SAMPLE_BITS-1:0]    den_reg;

    always_comb
    begin
        logic [qdra_pkg::SAMPLE_BITS:0] trial;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < qdra_pkg::DIV_STEP; i++)
        begin
            trial    = {rem_next, quo_next[qdra_pkg::DIV_BITS-1]};
            quo_next = {quo_next[qdra_pkg::DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = qdra_pkg::SAMPLE_BITS'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[qdra_pkg::SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == qdra_pkg::DIV_CNT_BITS'(qdra_pkg::DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[qdra_pkg::FIELD_BITS-1:0];

endmodule

// ===== rtl/core/quadrature_decoder_with_rate_averaging.sv =====
// an edge whose period exceeds the fast limit runs three passes of the shared divider
//   (edge period to microseconds, short average, long average) before its result is loaded
// other items go straight to the result, loaded once the output is free
// one item at a time, the next accepted once the result is loaded
// reset: asynchronous active low, clears position, edge timing, averages and config
//   (slow limit to all ones, clocks per us and sample counts to one)
module quadrature_decoder_with_rate_averaging
#(
    parameter int TIME_BITS     = 32,
    parameter int POSITION_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pin_level [0], timestamp [32:1], new_position [64:33], zero fill [71:65]
    input  logic [71:0]                         s_tdata,
    // cmd [1:0]
    input  logic [1:0]                          s_tuser,

    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // position [31:0], short_average [63:32], long_average [95:64],
    // fast_motion [96], slow_motion [97], zero fill [103:98]
    output logic [103:0]                        m_tdata,

    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qdra_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                         cfg_data
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [qdra_pkg::FIELD_BITS-1:0]  fast_limit_reg;
    logic [qdra_pkg::FIELD_BITS-1:0]  slow_limit_reg;
    logic [qdra_pkg::CPU_BITS-1:0]    clocks_per_us_reg;
    logic [qdra_pkg::SAMPLE_BITS-1:0] short_samples_reg;
    logic [qdra_pkg::SAMPLE_BITS-1:0] long_samples_reg;

    // ---------------------------------------------------------------
    // decoder and timing state
    // ---------------------------------------------------------------
    qdra_pkg::state_t                 state_reg;
    qdra_pkg::state_t                 state_next;
    logic                             a_level_reg;
    logic                             b_level_reg;
    logic [POSITION_BITS-1:0]         count_reg;
    logic [TIME_BITS-1:0]             prev_edge_time_reg;
    logic [qdra_pkg::FIELD_BITS-1:0]  edge_period_reg;
    logic [TIME_BITS-1:0]             logged_time_reg;
    logic [qdra_pkg::FIELD_BITS-1:0]  short_avg_reg;
    logic [qdra_pkg::FIELD_BITS-1:0]  long_avg_reg;
    logic [TIME_BITS-1:0]             ts_reg;
    logic [qdra_pkg::FIELD_BITS-1:0]  te_reg;

    logic                             m_tvalid_reg;
    logic [103:0]                     m_tdata_reg;

    // ---------------------------------------------------------------
    // input item fields
    // ---------------------------------------------------------------
    qdra_pkg::cmd_t                   in_cmd;
    logic                             in_level;
    logic [TIME_BITS-1:0]             in_ts;
    logic [POSITION_BITS-1:0]         in_pos;
    logic                             in_accept;
    logic                             in_edge;

    assign in_cmd    = qdra_pkg::cmd_t'(s_tuser);
    assign in_level  = s_tdata[0];
    assign in_ts     = TIME_BITS'(s_tdata[32:1]);
    // sign-extended or truncated to the position width
    assign in_pos    = POSITION_BITS'(signed'(s_tdata[64:33]));
    assign in_accept = s_tvalid && s_tready;
    assign in_edge   = (in_cmd == qdra_pkg::CMD_A_EDGE) || (in_cmd == qdra_pkg::CMD_B_EDGE);

    // phase rule: on an A edge count down when levels differ, on a B edge when they match
    logic                             a_new;
    logic                             b_new;
    logic                             count_down;
    logic [POSITION_BITS-1:0]         count_step;

    assign a_new      = (in_cmd == qdra_pkg::CMD_A_EDGE) ? in_level : a_level_reg;
    assign b_new      = (in_cmd == qdra_pkg::CMD_B_EDGE) ? in_level : b_level_reg;
    assign count_down = (in_cmd == qdra_pkg::CMD_A_EDGE) ? (a_new != b_new) : (a_new == b_new);
    assign count_step = count_down ? count_reg - 1'b1 : count_reg + 1'b1;

    // elapsed clocks wrap at the time width, the period keeps the low field bits
    logic [TIME_BITS-1:0]             elapsed;
    logic [qdra_pkg::FIELD_BITS-1:0]  period_new;
    logic                             average_go;

    assign elapsed    = in_ts - prev_edge_time_reg;
    assign period_new = qdra_pkg::FIELD_BITS'(elapsed);
    assign average_go = in_edge && (period_new > fast_limit_reg);

    // a zero divisor acts as one
    logic [qdra_pkg::CPU_BITS-1:0]    cpu_eff;
    logic [qdra_pkg::SAMPLE_BITS-1:0] short_n;
    logic [qdra_pkg::SAMPLE_BITS-1:0] long_n;

    assign cpu_eff = (clocks_per_us_reg == '0) ? qdra_pkg::CPU_BITS'(1) : clocks_per_us_reg;
    assign short_n = (short_samples_reg == '0) ? qdra_pkg::SAMPLE_BITS'(1) : short_samples_reg;
    assign long_n  = (long_samples_reg == '0) ? qdra_pkg::SAMPLE_BITS'(1) : long_samples_reg;

    // ---------------------------------------------------------------
    // shared multiplier: avg*(n-1) + te, feeding the divider directly
    // ---------------------------------------------------------------
    logic                              long_sel;
    logic [qdra_pkg::FIELD_BITS-1:0]   mul_avg;
    logic [qdra_pkg::SAMPLE_BITS-1:0]  mul_n;
    logic [qdra_pkg::PRODUCT_BITS-1:0] mul_product;
    logic [qdra_pkg::DIV_BITS-1:0]     mul_sum;

    assign long_sel    = (state_reg == qdra_pkg::ST_LONG_MUL);
    assign mul_avg     = long_sel ? long_avg_reg : short_avg_reg;
    assign mul_n       = long_sel ? long_n : short_n;
    assign mul_product = qdra_pkg::PRODUCT_BITS'(mul_avg) *
                         qdra_pkg::PRODUCT_BITS'(mul_n - 1'b1);
    assign mul_sum     = qdra_pkg::DIV_BITS'(mul_product) + qdra_pkg::DIV_BITS'(te_reg);

    // ---------------------------------------------------------------
    // shared serial divider
    // ---------------------------------------------------------------
    qdra_pkg::div_req_t div_req;
    qdra_pkg::div_rsp_t div_rsp;

    qdra_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // result flags, formed as the result is loaded
    // ---------------------------------------------------------------
    logic [TIME_BITS-1:0] since_logged;
    logic                 fast_flag;
    logic                 slow_flag;
    logic                 out_free;
    logic                 out_load;

    assign since_logged = ts_reg - logged_time_reg;
    assign fast_flag    = edge_period_reg < fast_limit_reg;
    assign slow_flag    = since_logged > slow_limit_reg;
    assign out_free     = !m_tvalid_reg || m_tready;

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qdra_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = average_go ? qdra_pkg::ST_TE_DIV : qdra_pkg::ST_DONE;
                end
            end
            qdra_pkg::ST_TE_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = qdra_pkg::ST_SHORT_MUL;
                end
            end
            qdra_pkg::ST_SHORT_MUL:
            begin
                state_next = qdra_pkg::ST_SHORT_DIV;
            end
            qdra_pkg::ST_SHORT_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = qdra_pkg::ST_LONG_MUL;
                end
            end
            qdra_pkg::ST_LONG_MUL:
            begin
                state_next = qdra_pkg::ST_LONG_DIV;
            end
            qdra_pkg::ST_LONG_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = qdra_pkg::ST_DONE;
                end
            end
            qdra_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = qdra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qdra_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        s_tready         = 1'b0;
        cfg_ready        = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mul_sum;
        div_req.divisor  = mul_n;
        case (state_reg)
            qdra_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                cfg_ready = 1'b1;
                // elapsed clocks to microseconds
                div_req.start    = in_accept && average_go;
                div_req.dividend = qdra_pkg::DIV_BITS'(period_new);
                div_req.divisor  = qdra_pkg::SAMPLE_BITS'(cpu_eff);
            end
            qdra_pkg::ST_SHORT_MUL,
            qdra_pkg::ST_LONG_MUL:
            begin
                div_req.start = 1'b1;
            end
            qdra_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= qdra_pkg::ST_IDLE;
            fast_limit_reg     <= '0;
            slow_limit_reg     <= '1;
            clocks_per_us_reg  <= qdra_pkg::CPU_BITS'(1);
            short_samples_reg  <= qdra_pkg::SAMPLE_BITS'(1);
            long_samples_reg   <= qdra_pkg::SAMPLE_BITS'(1);
            a_level_reg        <= 1'b0;
            b_level_reg        <= 1'b0;
            count_reg          <= '0;
            prev_edge_time_reg <= '0;
            edge_period_reg    <= '0;
            logged_time_reg    <= '0;
            short_avg_reg      <= '0;
            long_avg_reg       <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    qdra_pkg::CFG_FAST_LIMIT:    fast_limit_reg    <= cfg_data;
                    qdra_pkg::CFG_SLOW_LIMIT:    slow_limit_reg    <= cfg_data;
                    qdra_pkg::CFG_CLOCKS_PER_US: clocks_per_us_reg <= cfg_data[7:0];
                    qdra_pkg::CFG_SHORT_SAMPLES: short_samples_reg <= cfg_data[15:0];
                    qdra_pkg::CFG_LONG_SAMPLES:  long_samples_reg  <= cfg_data[15:0];
                    default:                     ;
                endcase
            end

            if (in_accept)
            begin
                case (in_cmd)
                    qdra_pkg::CMD_A_EDGE,
                    qdra_pkg::CMD_B_EDGE:
                    begin
                        a_level_reg        <= a_new;
                        b_level_reg        <= b_new;
                        count_reg          <= count_step;
                        prev_edge_time_reg <= in_ts;
                        edge_period_reg    <= period_new;
                        if (average_go)
                        begin
                            logged_time_reg <= in_ts;
                        end
                    end
                    qdra_pkg::CMD_POS_WRITE:
                    begin
                        count_reg <= in_pos;
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
            end

            if ((state_reg == qdra_pkg::ST_SHORT_DIV) && div_rsp.done)
            begin
                short_avg_reg <= div_rsp.quotient;
            end
            if ((state_reg == qdra_pkg::ST_LONG_DIV) && div_rsp.done)
            begin
                long_avg_reg <= div_rsp.quotient;
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ts_reg <= in_ts;
        end
        if ((state_reg == qdra_pkg::ST_TE_DIV) && div_rsp.done)
        begin
            te_reg <= div_rsp.quotient;
        end
        if (out_load)
        begin
            m_tdata_reg <= {6'b0, slow_flag, fast_flag, long_avg_reg, short_avg_reg,
                            qdra_pkg::FIELD_BITS'(count_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // the divider only answers while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == qdra_pkg::ST_TE_DIV) ||
                         (state_reg == qdra_pkg::ST_SHORT_DIV) ||
                         (state_reg == qdra_pkg::ST_LONG_DIV))
        else $error("divider done outside a divide state");

    // averaging only follows an edge slower than the fast limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qdra_pkg::ST_TE_DIV) |-> (edge_period_reg > fast_limit_reg))
        else $error("averaging started on a fast edge");

    // writes and queries go straight to the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !in_edge) |=> (state_reg == qdra_pkg::ST_DONE))
        else $error("write or query item took the averaging path");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("pending result lost");

    // the averaging path always ends in a result
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == qdra_pkg::ST_LONG_DIV) && div_rsp.done) |=>
            (state_reg == qdra_pkg::ST_DONE))
        else $error("long average finish did not lead to a result");

endmodule
